FILE: sv/glmm_pkg.sv
// ----------------------------------------------------------------------------
// glmm_pkg
// Shared types and constants for the grid local-minimum marker: cell value
// type, the neighbour tap bundle and the neighbour select bundle.
// ----------------------------------------------------------------------------
package glmm_pkg;

	localparam int VAL_W         = 8;
	localparam int ROW_WIDTH_DEF = 32;

	typedef logic [VAL_W-1:0] val_t;

	localparam val_t BORDER_RESET = val_t'(10);

	// Neighbour values read from the line taps for the cell under test
	typedef struct packed {
		val_t up;
		val_t left;
		val_t centre;
		val_t right;
	} taps_t;

	// Per-step control: whether a result is produced and which neighbours
	// come from the grid rather than the border value
	typedef struct packed {
		logic emit;
		logic use_up;
		logic use_left;
		logic use_right;
		logic use_down;
		logic last;
	} nsel_t;

endpackage

FILE: sv/glmm_line.sv
// ----------------------------------------------------------------------------
// glmm_line
// Two-row delay line of cell values. Each step shifts one value in; fixed
// taps give the cell one row back and its left, right and upper neighbours.
// ----------------------------------------------------------------------------
module glmm_line import glmm_pkg::*; #(
	parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  shift,
	input  val_t  din,
	output taps_t taps
);

	localparam int DEPTH = 2 * ROW_WIDTH;
	// right-hand tap; for a one-cell row the right neighbour is always border
	localparam int RTAP  = (ROW_WIDTH >= 2) ? ROW_WIDTH - 2 : 0;

	val_t line_q [DEPTH];

	// Advance the line by one cell
	always_ff @(posedge clk) begin
		if (shift) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	// Fixed taps relative to the next incoming cell
	assign taps.centre = line_q[ROW_WIDTH-1];
	assign taps.right  = line_q[RTAP];
	assign taps.left   = line_q[ROW_WIDTH];
	assign taps.up     = line_q[DEPTH-1];

endmodule

FILE: sv/glmm_judge.sv
// ----------------------------------------------------------------------------
// glmm_judge
// Substitutes the border value for neighbours outside the frame, compares the
// centre cell against its four neighbours and holds the result in the output
// register until the sink takes it.
// ----------------------------------------------------------------------------
module glmm_judge import glmm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  nsel_t sel,
	input  taps_t taps,
	input  val_t  down_val,
	input  val_t  border,
	output logic  out_free,
	output logic  m_tvalid,
	input  logic  m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_value
	output logic  m_tuser,        // [0] is_minimum
	output logic  m_tlast         // last_of_frame
);

	val_t up, down, left, right;
	logic is_min;
	logic load;
	logic o_valid_q;
	val_t o_value_q;
	logic o_min_q;
	logic o_last_q;

	// Pick grid or border for each neighbour
	assign up    = sel.use_up    ? taps.up    : border;
	assign down  = sel.use_down  ? down_val   : border;
	assign left  = sel.use_left  ? taps.left  : border;
	assign right = sel.use_right ? taps.right : border;

	// Strictly below all four
	assign is_min = (taps.centre < up) && (taps.centre < down) &&
	                (taps.centre < left) && (taps.centre < right);

	assign out_free = !o_valid_q || m_tready;
	assign load     = step && sel.emit;

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (load) begin
			o_valid_q <= 1'b1;
		end else if (m_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			o_value_q <= taps.centre;
			o_min_q   <= is_min;
			o_last_q  <= sel.last;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_value_q;
	assign m_tuser  = o_min_q;
	assign m_tlast  = o_last_q;

endmodule

FILE: sv/grid_local_minimum_marker.sv
// ----------------------------------------------------------------------------
// grid_local_minimum_marker
// Marks four-neighbour local minima in a row-major cell stream. A cell's
// result leaves when the cell below it arrives; frame end flushes the last row.
//
//   channel   | direction | tdata         | tuser       | tlast
//   s_*       | in        | cell_value    | -           | frame_end
//   m_*       | out       | out_value     | is_minimum  | last_of_frame
//   cfg_*     | in        | border_value  | -           | -
//
// One cell is accepted per cycle; its result (for the cell above) enters the
// output register at the next edge after acceptance while the sink keeps up.
// Frame end runs a flush of ROW_WIDTH steps through the two-row delay line:
// ROW_WIDTH-1-c silent steps when the frame ends at column c, then c+1
// results, each waiting while the output register is not free. Input is held
// during the flush.
// Reset clears the counters, the flush sequencer and all valid flags; the
// border register returns to 10. Line contents need no clearing.
// A stalled output holds the pipeline; the input register still takes one
// item while a result waits.
// ----------------------------------------------------------------------------
module grid_local_minimum_marker import glmm_pkg::*; #(
	parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] cell_value
	input  logic       s_tlast,    // frame_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_value
	output logic       m_tuser,    // [0] is_minimum
	output logic       m_tlast,    // last_of_frame
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata   // [7:0] border_value
);

	localparam int COL_W = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_WIDTH - 1);

	val_t border_q;

	logic valid_s1;
	val_t value_s1;
	logic fe_s1;

	logic [COL_W-1:0] col_q;
	logic [1:0]       rows_q;
	logic             flush_q;
	logic             pad_q;
	logic [COL_W-1:0] fcol_q;
	logic [COL_W-1:0] end_col_q;
	logic             fup_q;

	logic  out_free;
	logic  item_go;
	logic  flush_go;
	logic  step;
	nsel_t sel;
	taps_t taps;
	val_t  din;

	// Border register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q <= BORDER_RESET;
		end else if (cfg_we) begin
			border_q <= cfg_wdata;
		end
	end

	// Step enables
	assign item_go  = valid_s1 && !flush_q && out_free;
	assign flush_go = flush_q && (pad_q || out_free);
	assign step     = item_go || flush_go;
	assign s_tready = !valid_s1 || item_go;
	assign din      = item_go ? value_s1 : '0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (item_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			value_s1 <= s_tdata;
			fe_s1    <= s_tlast;
		end
	end

	// Neighbour selection for the current step
	always_comb begin
		if (item_go) begin
			sel.emit      = (rows_q != 2'd0);
			sel.use_up    = rows_q[1];
			sel.use_left  = (col_q != '0);
			sel.use_right = (col_q != LAST_COL);
			sel.use_down  = 1'b1;
			sel.last      = 1'b0;
		end else begin
			sel.emit      = !pad_q;
			sel.use_up    = fup_q;
			sel.use_left  = (fcol_q != '0);
			sel.use_right = (fcol_q != end_col_q);
			sel.use_down  = 1'b0;
			sel.last      = (fcol_q == end_col_q);
		end
	end

	// Column, row count and flush sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			rows_q    <= 2'd0;
			flush_q   <= 1'b0;
			pad_q     <= 1'b0;
			fcol_q    <= '0;
			end_col_q <= '0;
			fup_q     <= 1'b0;
		end else if (item_go) begin
			if (fe_s1) begin
				flush_q   <= 1'b1;
				end_col_q <= col_q;
				fup_q     <= (rows_q != 2'd0);
				col_q     <= '0;
				rows_q    <= 2'd0;
				if (col_q == LAST_COL) begin
					pad_q  <= 1'b0;
					fcol_q <= '0;
				end else begin
					pad_q  <= 1'b1;
					fcol_q <= col_q + COL_W'(1);
				end
			end else if (col_q == LAST_COL) begin
				col_q <= '0;
				if (!rows_q[1]) begin
					rows_q <= rows_q + 2'd1;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (flush_go) begin
			if (pad_q) begin
				if (fcol_q == LAST_COL) begin
					pad_q  <= 1'b0;
					fcol_q <= '0;
				end else begin
					fcol_q <= fcol_q + COL_W'(1);
				end
			end else if (fcol_q == end_col_q) begin
				flush_q <= 1'b0;
			end else begin
				fcol_q <= fcol_q + COL_W'(1);
			end
		end
	end

	glmm_line #(
		.ROW_WIDTH (ROW_WIDTH)
	) u_line (
		.clk   (clk),
		.shift (step),
		.din   (din),
		.taps  (taps)
	);

	glmm_judge u_judge (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.sel      (sel),
		.taps     (taps),
		.down_val (value_s1),
		.border   (border_q),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Row count saturates at two
	a_rows_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q != 2'd3)
		else $error("row count out of range");

	// A held item waits through the flush
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q && valid_s1) |=> valid_s1)
		else $error("input item lost during flush");

	// End column stays fixed while flushing
	a_end_col: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q && $past(flush_q)) |-> $stable(end_col_q))
		else $error("end column changed during flush");

	// Emitting flush column never passes the end column
	a_fcol: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q && !pad_q) |-> (fcol_q <= end_col_q))
		else $error("flush column beyond frame end");

endmodule

FILE: tb/grid_local_minimum_marker_test.sv
// ----------------------------------------------------------------------------
// grid_local_minimum_marker_test
// Self-checking bench for the four-neighbour local-minimum marker. A queue of
// cells feeds a stream driver with random gaps. A random-stall sink takes the
// results. Each accepted cell runs through a line-store predictor. It pushes
// the marks that cell should release, and every result leaving the block is
// compared with the oldest mark due. Frames vary in row count and in where
// they end. The border value is changed between frames and includes both
// extremes.
// ----------------------------------------------------------------------------
module grid_local_minimum_marker_test;
	import glmm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_W         = ROW_WIDTH_DEF;
	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 2 * ROW_W + 16;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_CELLS  = 300;
	localparam int MAX_REPORTS   = 10;
	localparam longint LIMIT_NS  = 64'd20_000_000;

	// Spread of cell values inside one frame
	typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_NEAR_BORDER} spread_t;

	typedef struct {
		val_t value;
		bit   frame_end;
	} cell_t;

	typedef struct {
		val_t value;
		bit   is_min;
		bit   last;
	} mark_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = '0;   // [7:0] cell_value
	logic       s_tlast   = 1'b0; // frame_end
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;          // [7:0] out_value
	logic       m_tuser;          // [0] is_minimum
	logic       m_tlast;          // last_of_frame
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = '0;   // [7:0] border_value

	// Stimulus and expectation stores
	cell_t cells_to_send[$];
	mark_t marks_due[$];

	// Predictor state
	val_t fresh_row [ROW_W];
	val_t last_row  [ROW_W];
	int   col_model;
	int   rows_model;
	val_t border_model;

	// Run bookkeeping
	int  cells_queued    = 0;
	int  cells_accepted  = 0;
	int  results_checked = 0;
	int  mismatches      = 0;
	int  frames_sent     = 0;
	int  border_writes   = 0;
	int  hold_requests   = 0;
	bit  src_calm        = 1'b0;
	bit  snk_calm        = 1'b0;

	grid_local_minimum_marker #(
		.ROW_WIDTH(ROW_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// Mostly short gaps, now and then a long one; none when calm
	function automatic int next_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit strictly_lowest(input val_t v, input val_t up, input val_t down,
			input val_t left, input val_t right);
		return v < up && v < down && v < left && v < right;
	endfunction

	// Advance the line-store model by one cell and queue the marks it releases
	task automatic mark_minima(input val_t v, input bit fe);
		int   c;
		val_t ctr;
		val_t up;
		val_t left;
		val_t right;
		val_t tmp;
		mark_t m;
		c = col_model;
		// The cell above the incoming one is now complete
		if (rows_model >= 1) begin
			ctr      = last_row[c];
			up       = (rows_model >= 2) ? fresh_row[c] : border_model;
			left     = (c > 0) ? last_row[c-1] : border_model;
			right    = (c + 1 < ROW_W) ? last_row[c+1] : border_model;
			m.value  = ctr;
			m.is_min = strictly_lowest(ctr, up, v, left, right);
			m.last   = 1'b0;
			marks_due.push_back(m);
		end
		fresh_row[c] = v;
		if (fe) begin
			// Flush the row in progress with border below it
			for (int x = 0; x <= c; x++) begin
				ctr      = fresh_row[x];
				up       = (rows_model >= 1) ? last_row[x] : border_model;
				left     = (x > 0) ? fresh_row[x-1] : border_model;
				right    = (x < c) ? fresh_row[x+1] : border_model;
				m.value  = ctr;
				m.is_min = strictly_lowest(ctr, up, border_model, left, right);
				m.last   = (x == c);
				marks_due.push_back(m);
			end
			col_model  = 0;
			rows_model = 0;
		end else if (c + 1 >= ROW_W) begin
			// Row complete: swap the line stores
			for (int x = 0; x < ROW_W; x++) begin
				tmp          = fresh_row[x];
				fresh_row[x] = last_row[x];
				last_row[x]  = tmp;
			end
			col_model = 0;
			if (rows_model < 2)
				rows_model++;
		end else begin
			col_model = c + 1;
		end
	endtask

	// Drive cells from the queue, holding each one until it is taken
	always @(posedge clk or negedge arst_n) begin : drive_cells
		cell_t nxt;
		int    gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap > 0 || cells_to_send.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap > 0)
					gap--;
			end else begin
				nxt = cells_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nxt.value;
				s_tlast  <= nxt.frame_end;
				gap = next_gap(src_calm);
			end
		end
	end

	// Sink readiness: random stalls plus the requested long hold-offs
	always @(posedge clk or negedge arst_n) begin : drive_ready
		int stall;
		int holds_served;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
			holds_served = 0;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			stall = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall = next_gap(snk_calm);
		end
	end

	// Predict on every accepted cell, check every accepted result
	always @(posedge clk) begin : watch_streams
		mark_t exp;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				mark_minima(s_tdata, s_tlast);
				cells_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (marks_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: value %0d min %b last %b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					exp = marks_due.pop_front();
					results_checked++;
					if (m_tdata !== exp.value || m_tuser !== exp.is_min
							|| m_tlast !== exp.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"result %0d: expected value %0d min %b last %b, ",
								"got value %0d min %b last %b"}, results_checked,
								exp.value, exp.is_min, exp.last, m_tdata, m_tuser, m_tlast);
					end
				end
			end
		end
	end

	task automatic push_cell(input val_t v, input bit fe);
		cell_t c;
		c.value = v;
		c.frame_end = fe;
		cells_to_send.push_back(c);
		cells_queued++;
		if (fe)
			frames_sent++;
	endtask

	function automatic val_t pick_value(input spread_t spread);
		int lo;
		int hi;
		case (spread)
			SPREAD_NARROW: begin
				return val_t'($urandom_range(0, 3));
			end
			SPREAD_NEAR_BORDER: begin
				lo = (border_model < 2) ? 0 : border_model - 2;
				hi = (border_model > 253) ? 255 : border_model + 2;
				return val_t'($urandom_range(lo, hi));
			end
			default: begin
				return val_t'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// Queue one frame: full rows, then a last row that may end early
	task automatic push_frame(input int rows, input int last_len, input spread_t spread);
		int total;
		total = (rows - 1) * ROW_W + last_len;
		for (int i = 0; i < total; i++)
			push_cell(pick_value(spread), i == total - 1);
	endtask

	// Hold until every cell is taken and every mark has come, then let the flush drain
	task automatic settle();
		while (!(cells_accepted == cells_queued && marks_due.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_border(input val_t v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		border_model = v;
		border_writes++;
	endtask

	initial begin : stimulus
		int      random_start;
		int      phase;
		int      frames;
		int      rows;
		int      last_len;
		int      pick;
		spread_t spread;
		for (int x = 0; x < ROW_W; x++) begin
			fresh_row[x] = '0;
			last_row[x]  = '0;
		end
		col_model    = 0;
		rows_model   = 0;
		border_model = BORDER_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Single-cell frames around the reset border, then a short row ending early
		push_cell(8'd0, 1'b1);
		push_cell(8'd255, 1'b1);
		push_cell(BORDER_RESET, 1'b1);
		push_cell(BORDER_RESET - 8'd1, 1'b1);
		push_cell(8'd5, 1'b0);
		push_cell(8'd2, 1'b0);
		push_cell(8'd7, 1'b0);
		push_cell(8'd0, 1'b0);
		push_cell(8'd255, 1'b1);
		settle();

		// Border at zero: nothing can sit strictly below it
		write_border(8'd0);
		push_cell(8'd0, 1'b1);
		push_cell(8'd3, 1'b0);
		push_cell(8'd1, 1'b0);
		push_cell(8'd2, 1'b1);
		settle();

		// Border at full scale
		write_border(8'd255);
		push_cell(8'd254, 1'b1);
		push_cell(8'd255, 1'b1);
		push_cell(8'd200, 1'b0);
		push_cell(8'd100, 1'b0);
		push_cell(8'd254, 1'b1);
		settle();

		// Random frames, phase by phase, with border changes between phases
		random_start = cells_queued;
		phase = 0;
		while (cells_queued - random_start < RANDOM_CELLS) begin
			src_calm = ($urandom_range(0, 3) == 0);
			snk_calm = ($urandom_range(0, 3) == 0);
			if (phase > 0 && $urandom_range(0, 1) == 0) begin
				pick = $urandom_range(0, 4);
				if (pick == 0)
					write_border(8'd0);
				else if (pick == 1)
					write_border(8'd255);
				else if (pick == 2)
					write_border(BORDER_RESET);
				else
					write_border(val_t'($urandom_range(0, 255)));
			end
			if (phase == 1) begin
				// Hold the sink off while a deep frame keeps coming, to back up the input
				src_calm = 1'b1;
				hold_requests++;
				push_frame(3, ROW_W, SPREAD_FULL);
			end else begin
				frames = $urandom_range(1, 2);
				repeat (frames) begin
					rows = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 4)
						: $urandom_range(1, 2);
					last_len = ($urandom_range(0, 9) < 6) ? ROW_W : $urandom_range(1, ROW_W);
					spread = spread_t'($urandom_range(0, 2));
					push_frame(rows, last_len, spread);
				end
			end
			settle();
			phase++;
		end

		$display("Covered %0d frames, %0d cells, %0d results checked, %0d border writes.",
			frames_sent, cells_accepted, results_checked, border_writes);
		$display("Included early frame ends, single-row frames and a long sink hold-off.");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

	// Give up if the run hangs
	initial begin : watchdog
		#(LIMIT_NS);
		$display("timeout with %0d marks still due", marks_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule
